>>> rtl/core/multiset_count_table_defines.svh
// ---------------------------------------------------------------------------
// multiset_count_table assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef MULTISET_COUNT_TABLE_DEFINES_SVH
`define MULTISET_COUNT_TABLE_DEFINES_SVH

`ifndef SYNTH
`define MCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MCT_ASSERT(lbl, prop, msg)
`define MCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/mct_pkg.sv
// ---------------------------------------------------------------------------
// mct_pkg
// shared constants, codes and payload types of the multiset count table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mct_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OCC_W    = 7;

  localparam logic signed [VAL_W-1:0] EMPTY_MARKER_RST = -32'sd111111;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_LEAST  = 2'd3
  } mct_action_e;

  typedef enum logic [1:0] {
    STS_DONE   = 2'd0,
    STS_ABSENT = 2'd1,
    STS_FULL   = 2'd2
  } mct_status_e;

  typedef struct packed {
    mct_action_e              action;
    logic signed [VAL_W-1:0]  value;
  } mct_in_t;

  typedef struct packed {
    mct_status_e              status;
    logic                     found;
    logic [OCC_W-1:0]         occurrences;
    logic signed [VAL_W-1:0]  least_value;
    logic [OCC_W-1:0]         total_size;
    logic                     is_empty;
  } mct_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              cmp_en;
    logic              inc;
    logic              put;
    logic              dec;
    logic              scan;
    logic [VAL_W-1:0]  value;
  } mct_cmd_t;

  // running least-frequent candidate handed down the row
  typedef struct packed {
    logic              have;
    logic [CNT_W-1:0]  cnt;
    logic [VAL_W-1:0]  value;
  } mct_cand_t;

endpackage

>>> rtl/core/mct_cell.sv
// ---------------------------------------------------------------------------
// mct_cell
// one table slot: value, count, match flag, compaction shift and min scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mct_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mct_pkg::mct_cmd_t             cmd_i,
  input  logic                          prev_valid_i,
  input  logic                          shift_i,
  input  logic [mct_pkg::VAL_W-1:0]     next_value_i,
  input  logic [mct_pkg::CNT_W-1:0]     next_count_i,
  input  mct_pkg::mct_cand_t            cand_i,
  output logic                          valid_o,
  output logic                          free_o,
  output logic                          hit_o,
  output logic                          shift_o,
  output logic [mct_pkg::VAL_W-1:0]     value_o,
  output logic [mct_pkg::CNT_W-1:0]     count_o,
  output mct_pkg::mct_cand_t            cand_o
);
  import mct_pkg::*;

  logic [VAL_W-1:0] value_q;
  logic [CNT_W-1:0] count_q;
  logic             match_q;
  mct_cand_t        cand_q;
  logic             valid;

  assign valid   = (count_q != '0);
  assign hit_o   = valid && (value_q == cmd_i.value);
  assign free_o  = !valid && prev_valid_i;
  assign shift_o = shift_i || (match_q && (count_q == CNT_W'(1)));
  assign valid_o = valid;
  assign value_o = value_q;
  assign count_o = count_q;
  assign cand_o  = cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      match_q <= 1'b0;
    end else begin
      if (cmd_i.cmp_en) begin
        match_q <= hit_o;
      end
      if (cmd_i.dec && shift_o) begin
        count_q <= next_count_i;
      end else if (cmd_i.dec && match_q) begin
        count_q <= count_q - CNT_W'(1);
      end else if (cmd_i.inc && match_q) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.put && free_o) begin
        count_q <= CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec && shift_o) begin
      value_q <= next_value_i;
    end else if (cmd_i.put && free_o) begin
      value_q <= cmd_i.value;
    end
    if (cmd_i.scan) begin
      if (valid && (!cand_i.have || (count_q < cand_i.cnt))) begin
        cand_q <= '{have: 1'b1, cnt: count_q, value: value_q};
      end else begin
        cand_q <= cand_i;
      end
    end
  end

endmodule

>>> rtl/core/multiset_count_table.sv
// ---------------------------------------------------------------------------
// multiset_count_table
// add, remove and lookup: accepted in S_IDLE, compared in S_CMP, result
// loaded from S_UPD; least-frequent: the candidate walks the cell row in
// S_SCAN, result loaded from S_DONE; next request taken once back in S_IDLE
// a full output register holds the row until the result is taken
// reset clears all counts, the total and the controller, no clearing pass
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiset_count_table_defines.svh"

module multiset_count_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mct_pkg::mct_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mct_pkg::mct_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mct_pkg::VAL_W-1:0]     cfg_data_i
);
  import mct_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  mct_in_t           op_q;
  logic              found_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [IDX_W-1:0]  scan_q;
  logic [VAL_W-1:0]  marker_q;
  mct_out_t          out_q, res;
  logic              out_valid_q, out_load, out_free;
  mct_cmd_t          cmd;
  logic              inc, put, dec;
  logic [CNT_W-1:0]  occ;

  logic [CAPACITY-1:0] valid, free, hit, shift;
  logic [VAL_W-1:0]    val [CAPACITY];
  logic [CNT_W-1:0]    cnt [CAPACITY];
  mct_cand_t           cand [CAPACITY];
  logic                found_c;
  logic [CNT_W-1:0]    hit_cnt;
  mct_cand_t           best;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic             prev_v, shift_in;
      logic [VAL_W-1:0] next_v;
      logic [CNT_W-1:0] next_c;
      mct_cand_t        cand_in;
      if (g == 0) begin : g_first
        assign prev_v   = 1'b1;
        assign shift_in = 1'b0;
        assign cand_in  = '0;
      end else begin : g_mid
        assign prev_v   = valid[g-1];
        assign shift_in = shift[g-1];
        assign cand_in  = cand[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_v = '0;
        assign next_c = '0;
      end else begin : g_inner
        assign next_v = val[g+1];
        assign next_c = cnt[g+1];
      end
      mct_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .cmd_i        (cmd),
        .prev_valid_i (prev_v),
        .shift_i      (shift_in),
        .next_value_i (next_v),
        .next_count_i (next_c),
        .cand_i       (cand_in),
        .valid_o      (valid[g]),
        .free_o       (free[g]),
        .hit_o        (hit[g]),
        .shift_o      (shift[g]),
        .value_o      (val[g]),
        .count_o      (cnt[g]),
        .cand_o       (cand[g])
      );
    end
  endgenerate

  assign best    = cand[CAPACITY-1];
  assign found_c = |hit;

  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_cnt = hit_cnt | (hit[i] ? cnt[i] : '0);
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cmd.cmp_en = (state_q == S_CMP);
  assign cmd.inc    = inc;
  assign cmd.put    = put;
  assign cmd.dec    = dec;
  assign cmd.scan   = (state_q == S_SCAN);
  assign cmd.value  = op_q.value;

  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    out_load = 1'b0;
    inc      = 1'b0;
    put      = 1'b0;
    dec      = 1'b0;
    occ      = '0;
    res.status      = STS_DONE;
    res.found       = 1'b0;
    res.least_value = marker_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.action == ACT_LEAST) ? S_SCAN : S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_d   = S_IDLE;
          res.found = found_q;
          unique case (op_q.action)
            ACT_ADD: begin
              if (total_q >= CNT_W'(CAPACITY)) begin
                res.status = STS_FULL;
                occ        = found_q ? cnt_q : '0;
              end else if (found_q) begin
                inc     = 1'b1;
                occ     = cnt_q + CNT_W'(1);
                total_d = total_q + CNT_W'(1);
              end else begin
                put     = 1'b1;
                occ     = CNT_W'(1);
                total_d = total_q + CNT_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (!found_q) begin
                res.status = STS_ABSENT;
              end else begin
                dec     = 1'b1;
                occ     = cnt_q - CNT_W'(1);
                total_d = total_q - CNT_W'(1);
              end
            end
            ACT_LOOKUP: begin
              occ = found_q ? cnt_q : '0;
            end
            ACT_LEAST: begin
              res.found = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_q == IDX_W'(CAPACITY - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          state_d         = S_IDLE;
          res.found       = best.have;
          occ             = best.have ? best.cnt : '0;
          res.least_value = best.have ? best.value : marker_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res.occurrences = OCC_W'(occ);
    res.total_size  = OCC_W'(total_d);
    res.is_empty    = (total_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      marker_q    <= EMPTY_MARKER_RST;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (state_q == S_SCAN) begin
        scan_q <= scan_q + IDX_W'(1);
      end else begin
        scan_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        marker_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= in_data_i;
    end
    if (state_q == S_CMP) begin
      found_q <= found_c;
      cnt_q   <= hit_cnt;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  `MCT_ASSERT(a_total_in_range, total_q <= CNT_W'(CAPACITY), "total exceeds capacity")
  `MCT_ASSERT(a_unique_hit, $onehot0(hit), "value held in more than one cell")
  `MCT_ASSERT(a_put_has_slot, put |-> $onehot(free), "no single free cell for new value")
  `MCT_ASSERT(a_scan_keeps_total, state_q == S_SCAN |=> $stable(total_q), "total moved in scan")
  `MCT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> state_q == S_IDLE || !rst_ni, "not idle after reset")

endmodule
